/* hdl/rhsh_pkg.sv */
// Shared types and constants for the random hyperplane sign hash block.
`default_nettype none
package rhsh_pkg;

    // Mix-round multipliers and the per-bit offset.
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN_OFS = 64'h9e3779b97f4a7c15;

    // Status codes reported with each signature.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEED    = 2'd0;
    localparam logic [1:0] REG_VEC_LEN = 2'd1;
    localparam logic [1:0] REG_SIG_LEN = 2'd2;

    // One classified element as it travels from front to back.
    typedef struct packed {
        logic [11:0]        idx;
        logic signed [15:0] val;
        logic               ok;
        logic               last;
        logic [1:0]         status;
    } q_item_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_MIX1,
        B_MIX2,
        B_UPD,
        B_SRD,
        B_SCHK,
        B_EMIT
    } back_state_t;

    // Control strobes from the back sequencer to its datapath.
    typedef struct packed {
        logic mem_rd;
        logic mix_start;
        logic mix_second;
        logic acc_wr;
        logic bit_clr;
        logic bit_inc;
        logic sig_chk;
        logic emit;
        logic pop;
    } back_ctrl_t;

endpackage
`default_nettype wire

/* hdl/rhsh_front.sv */
// Front end: accepts elements, checks index range and order, tracks the vector status.
`default_nettype none
module rhsh_front
    import rhsh_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // elem_index[11:0], elem_value[27:12], zero pad
    input  wire logic        s_tlast,   // elem_last
    input  wire logic [12:0] vec_len,
    input  wire logic        q_full,
    output logic             q_push,
    output q_item_t          q_item
);

    logic [11:0] prior_idx_reg, prior_idx_next;
    logic        seen_reg, seen_next;
    logic [1:0]  err_reg, err_next;
    logic [16:0] len_eff;
    logic [11:0] idx;
    logic [1:0]  code;
    logic [1:0]  status_now;

    assign idx      = s_tdata[11:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Effective length is the register capped at the dimension limit.
    always_comb begin
        if (32'(vec_len) > 32'(MAX_DIMENSION)) begin
            len_eff = 17'(MAX_DIMENSION);
        end else begin
            len_eff = 17'(vec_len);
        end
    end

    // Classify the element; the range test wins over the order test.
    always_comb begin
        if (17'(idx) >= len_eff) begin
            code = ST_RANGE;
        end else if (seen_reg && idx <= prior_idx_reg) begin
            code = ST_ORDER;
        end else begin
            code = ST_OK;
        end
        status_now = (err_reg == ST_OK) ? code : err_reg;
    end

    assign q_item.idx    = idx;
    assign q_item.val    = s_tdata[27:12];
    assign q_item.ok     = (code == ST_OK);
    assign q_item.last   = s_tlast;
    assign q_item.status = status_now;

    // Order tracking and first error; all clear at the end of a vector.
    always_comb begin
        prior_idx_next = prior_idx_reg;
        seen_next      = seen_reg;
        err_next       = err_reg;
        if (q_push) begin
            if (s_tlast) begin
                prior_idx_next = '0;
                seen_next      = 1'b0;
                err_next       = ST_OK;
            end else begin
                err_next = status_now;
                if (code == ST_OK) begin
                    prior_idx_next = idx;
                    seen_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_idx_reg <= '0;
            seen_reg      <= 1'b0;
            err_reg       <= ST_OK;
        end else begin
            prior_idx_reg <= prior_idx_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/rhsh_fifo.sv */
// Short queue of classified elements between the front and back ends.
`default_nettype none
module rhsh_fifo
    import rhsh_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire q_item_t push_item,
    input  wire logic    pop,
    output q_item_t      head,
    output logic         empty,
    output logic         full
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    q_item_t       slot_reg [DEPTH];
    logic [PW:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW:0]   rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]) &&
                   (wr_ptr_reg[PW] != rd_ptr_reg[PW]);
    assign head  = slot_reg[rd_ptr_reg[PW-1:0]];

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    // Pointers carry one extra wrap bit to tell full from empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg[PW-1:0]] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/rhsh_mix.sv */
// Iterative 64-bit mix round built on one shared 32x32 multiplier.
`default_nettype none
module rhsh_mix
    import rhsh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] x_in,
    output logic             done,
    output logic [63:0]      x_out
);

    localparam logic [3:0] LAST_STEP = 4'd8;

    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_a, op_c;
    logic [63:0] prod;

    // Operand selection: low*low, low*high, high*low of each 64-bit product.
    always_comb begin
        op_a = ((step_reg == 4'd3) || (step_reg == 4'd7)) ? x_reg[63:32] : x_reg[31:0];
        case (step_reg)
            4'd1, 4'd3: op_c = MIX_MUL_A[31:0];
            4'd2:       op_c = MIX_MUL_A[63:32];
            4'd6:       op_c = MIX_MUL_B[63:32];
            default:    op_c = MIX_MUL_B[31:0];
        endcase
    end

    assign prod = 64'(op_a) * 64'(op_c);

    // One step per cycle: shift-xor, three partial products, repeat, shift-xor.
    always_comb begin
        x_next    = x_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x_in ^ (x_in >> 30);
            step_next = 4'd1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            case (step_reg)
                4'd1, 4'd5: acc_next = prod;
                4'd2, 4'd6: acc_next = acc_reg + {prod[31:0], 32'd0};
                4'd3, 4'd7: x_next = acc_reg + {prod[31:0], 32'd0};
                4'd4:       x_next = x_reg ^ (x_reg >> 27);
                default: begin
                    x_next    = x_reg ^ (x_reg >> 31);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
            if (step_reg == LAST_STEP) begin
                step_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;

endmodule
`default_nettype wire

/* hdl/rhsh_back.sv */
// Back end: per-bit sign hashing, accumulator updates and signature output.
`default_nettype none
module rhsh_back
    import rhsh_pkg::*;
#(
    parameter int MAX_SIGNATURE_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire q_item_t     head,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire logic [63:0] seed,
    input  wire logic [6:0]  sig_len,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // signature_word[63:0], status_code[65:64], zero pad
);

    localparam int AW = (MAX_SIGNATURE_BITS > 1) ? $clog2(MAX_SIGNATURE_BITS) : 1;

    back_state_t state_reg, state_next;
    back_ctrl_t  ctrl;

    logic [31:0]              acc_mem [MAX_SIGNATURE_BITS];
    logic [31:0]              rd_reg;
    logic [MAX_SIGNATURE_BITS-1:0] valid_reg, valid_next;
    logic [6:0]               bit_reg, bit_next;
    logic [63:0]              sig_reg, sig_next;
    logic                     out_valid_reg, out_valid_next;
    logic [71:0]              out_data_reg, out_data_next;
    logic [6:0]               bits;
    logic                     bit_end;
    logic [AW-1:0]            addr;
    logic [31:0]              base;
    logic [31:0]              val32;
    logic [31:0]              wdata;
    logic [63:0]              mix_in;
    logic                     mix_done;
    logic [63:0]              mix_x;
    logic                     out_free;

    // Bit count capped at the accumulator depth.
    assign bits    = (32'(sig_len) > 32'(MAX_SIGNATURE_BITS)) ? 7'(MAX_SIGNATURE_BITS) : sig_len;
    assign bit_end = (bit_reg + 7'd1 == bits);
    assign addr    = bit_reg[AW-1:0];
    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (head.ok && bits != 7'd0) begin
                        state_next = B_START;
                    end else if (head.last) begin
                        state_next = (bits != 7'd0 && head.status == ST_OK) ? B_SRD : B_EMIT;
                    end
                end
            end
            B_START: state_next = B_MIX1;
            B_MIX1:  state_next = mix_done ? B_MIX2 : B_MIX1;
            B_MIX2:  state_next = mix_done ? B_UPD : B_MIX2;
            B_UPD: begin
                if (!bit_end) begin
                    state_next = B_START;
                end else if (head.last) begin
                    state_next = (head.status == ST_OK) ? B_SRD : B_EMIT;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_SRD:  state_next = B_SCHK;
            B_SCHK: state_next = bit_end ? B_EMIT : B_SRD;
            B_EMIT: state_next = out_free ? B_IDLE : B_EMIT;
            default: state_next = B_IDLE;
        endcase
    end

    // Control strobes per state.
    always_comb begin
        ctrl = '0;
        case (state_reg)
            B_IDLE: begin
                ctrl.bit_clr = 1'b1;
                ctrl.pop     = !q_empty && !(head.ok && bits != 7'd0) && !head.last;
            end
            B_START: begin
                ctrl.mem_rd    = 1'b1;
                ctrl.mix_start = 1'b1;
            end
            B_MIX1: begin
                ctrl.mix_start  = mix_done;
                ctrl.mix_second = 1'b1;
            end
            B_UPD: begin
                ctrl.acc_wr  = 1'b1;
                ctrl.bit_inc = !bit_end;
                ctrl.bit_clr = bit_end;
                ctrl.pop     = bit_end && !head.last;
            end
            B_SRD: ctrl.mem_rd = 1'b1;
            B_SCHK: begin
                ctrl.sig_chk = 1'b1;
                ctrl.bit_inc = 1'b1;
            end
            B_EMIT: begin
                ctrl.emit = out_free;
                ctrl.pop  = out_free;
            end
            default: ctrl = '0;
        endcase
    end

    assign q_pop = ctrl.pop;

    // Hash input: seed with bit offset, then the index with its offset.
    assign mix_in = ctrl.mix_second ? (mix_x ^ (64'(head.idx) + MIX_MUL_A))
                                    : (seed ^ (64'(bit_reg) + GOLDEN_OFS));

    rhsh_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mix_start),
        .x_in    (mix_in),
        .done    (mix_done),
        .x_out   (mix_x)
    );

    // Accumulator update; an entry not yet written since clearing reads as zero.
    assign base  = valid_reg[addr] ? rd_reg : 32'd0;
    assign val32 = 32'(head.val);
    assign wdata = mix_x[0] ? base + val32 : base - val32;

    always_ff @(posedge aclk) begin
        if (ctrl.acc_wr) begin
            acc_mem[addr] <= wdata;
        end
        if (ctrl.mem_rd) begin
            rd_reg <= acc_mem[addr];
        end
    end

    // Bit counter, valid bits, signature assembly and output register.
    always_comb begin
        bit_next       = bit_reg;
        valid_next     = valid_reg;
        sig_next       = sig_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (ctrl.bit_clr) begin
            bit_next = '0;
        end else if (ctrl.bit_inc) begin
            bit_next = bit_reg + 7'd1;
        end
        if (ctrl.acc_wr) begin
            valid_next[addr] = 1'b1;
        end
        if (ctrl.sig_chk) begin
            sig_next[bit_reg[5:0]] = (base != 32'd0) && !base[31];
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (ctrl.emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {6'd0, head.status,
                              (head.status == ST_OK) ? sig_reg : 64'd0};
            valid_next     = '0;
            sig_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            bit_reg       <= '0;
            valid_reg     <= '0;
            sig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            valid_reg     <= valid_next;
            sig_reg       <= sig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

/* hdl/random_hyperplane_sign_hash.sv */
// An ok element is processed one signature bit at a time, paced by the shared
// iterative mix unit: per bit, a memory read, two mix rounds and an accumulator update.
// A last element adds a read-and-check sweep of the accumulator memory, then an emit.
// The back end works on one element at a time; a bad element is popped without hashing.
// Reset (aresetn, synchronous, active low) clears control state, the accumulator
// valid bits and restores seed 0, vector length 768 and signature length 64.
`default_nettype none
module random_hyperplane_sign_hash
    import rhsh_pkg::*;
#(
    parameter int MAX_SIGNATURE_BITS = 64,
    parameter int MAX_DIMENSION      = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // elem_index[11:0], elem_value[27:12], zero pad
    input  wire logic        s_tlast,   // elem_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // signature_word[63:0], status_code[65:64], zero pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);

    logic [63:0] seed_reg;
    logic [12:0] vec_len_reg;
    logic [6:0]  sig_len_reg;
    q_item_t     push_item;
    q_item_t     head;
    logic        push, pop, empty, full;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= '0;
            vec_len_reg <= 13'd768;
            sig_len_reg <= 7'd64;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SEED:    seed_reg    <= cfg_wdata;
                REG_VEC_LEN: vec_len_reg <= cfg_wdata[12:0];
                REG_SIG_LEN: sig_len_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    rhsh_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .vec_len  (vec_len_reg),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    rhsh_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    rhsh_back #(.MAX_SIGNATURE_BITS(MAX_SIGNATURE_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (empty),
        .q_pop    (pop),
        .seed     (seed_reg),
        .sig_len  (sig_len_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

/* hdl/rhsh_checker.sv */
// Port-level checker for the sign hash block, bound to the top level.
`default_nettype none
module rhsh_checker
    import rhsh_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Only defined status codes appear.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:64] == ST_OK || m_tdata[65:64] == ST_RANGE ||
                      m_tdata[65:64] == ST_ORDER))
        else $error("undefined status code");

    // An errored vector reports an all-zero signature.
    a_errzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65:64] != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("signature not zero on error");

    // No result right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind random_hyperplane_sign_hash rhsh_checker u_rhsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
